@@ src/sample_voice_mixer_defines.svh @@
// ----------------------------------------------------------------------------
// Sample voice mixer assertion macros
// Shared concurrent assertion forms used by the checker of the mixer.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_VOICE_MIXER_DEFINES_SVH
`define SAMPLE_VOICE_MIXER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SVM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SVM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/svm_pkg.sv @@
// ----------------------------------------------------------------------------
// Sample voice mixer package
// Shared types, constants and the tanh lookup contents.
// ----------------------------------------------------------------------------
`default_nettype none

package svm_pkg;

  // Default configuration of the mixer
  localparam int NumVoicesDef   = 24;
  localparam int MaxSamplesDef  = 131072;
  localparam int MaxSamplesHigh = 1048576;

  // Field widths of the item channels
  localparam int KIND_W    = 2;
  localparam int VOICE_W   = 5;
  localparam int ADDRESS_W = 17;
  localparam int SAMPLE_W  = 16;
  localparam int LENGTH_W  = 18;
  localparam int GAIN_W    = 15;

  // Saturated length as carried in a command, wide enough for any region size
  localparam int CMD_LEN_W = $clog2(MaxSamplesHigh + 1);

  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd26214;

  // Command queue between front and back
  localparam int CMD_FIFO_DEPTH = 4;
  localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);

  // tanh lookup
  localparam int               TANH_ENTRIES = 1024;
  localparam int               TANH_IDX_W   = $clog2(TANH_ENTRIES);
  localparam int               TANH_W       = 15;
  localparam logic [TANH_W-1:0] OUT_MAX     = 15'd32767;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 2'd0,
    KIND_TRIGGER = 2'd1,
    KIND_WRITE   = 2'd2,
    KIND_LENGTH  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WALK,
    BK_SUM,
    BK_MUL,
    BK_LOOK,
    BK_SEND
  } bk_state_e;

  typedef struct packed {
    kind_e                 op;
    logic [VOICE_W-1:0]    voice;
    logic [ADDRESS_W-1:0]  address;
    logic [SAMPLE_W-1:0]   sample;
    logic [CMD_LEN_W-1:0]  length;
  } cmd_t;

  typedef logic [TANH_W-1:0] tanh_rom_t [TANH_ENTRIES];

  // Build 32767*tanh(i/256) from a Q24 exponential recurrence e^(2i/256)
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t   rom;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] dvd;
    logic [63:0] rem;
    logic [63:0] q;
    e = 64'd16777216;
    for (int i = 0; i < TANH_ENTRIES; i++) begin
      num = e - 64'd16777216;
      den = e + 64'd16777216;
      dvd = num * 64'd32767 + (den >> 1);
      // Rounded quotient by shift and subtract
      rem = '0;
      q   = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], dvd[b]};
        if (rem >= den) begin
          rem  = rem - den;
          q[b] = 1'b1;
        end
      end
      rom[i] = q[TANH_W-1:0];
      e      = (e * 64'd16908801 + 64'd8388608) >> 24;
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

`default_nettype wire

@@ src/svm_ifs.sv @@
// ----------------------------------------------------------------------------
// Sample voice mixer channel interfaces
// Valid/ready channels for input items, result items and the gain register.
// ----------------------------------------------------------------------------
`default_nettype none

interface svm_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [4:0]          voice;
  logic [16:0]         address;
  logic signed [15:0]  sample_value;
  logic [17:0]         length;

  modport source (output valid, kind, voice, address, sample_value, length, input ready);
  modport sink   (input valid, kind, voice, address, sample_value, length, output ready);
endinterface

interface svm_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  audio_out;

  modport source (output valid, audio_out, input ready);
  modport sink   (input valid, audio_out, output ready);
endinterface

interface svm_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] output_gain;

  modport source (output valid, output_gain, input ready);
  modport sink   (input valid, output_gain, output ready);
endinterface

`default_nettype wire

@@ src/svm_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire                      clk_i,
  input  wire                      wr_en_i,
  input  wire [$clog2(DEPTH)-1:0]  wr_addr_i,
  input  wire [WIDTH-1:0]          wr_data_i,
  input  wire                      rd_en_i,
  input  wire [$clog2(DEPTH)-1:0]  rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/svm_front.sv @@
// ----------------------------------------------------------------------------
// Sample voice mixer front end
// Accepts items, drops those without effect and turns the rest into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_front #(
  parameter int NUM_VOICES  = 24,
  parameter int MAX_SAMPLES = 131072
) (
  svm_in_if.sink           in_ch,
  input  wire              fifo_full_i,
  output logic             push_o,
  output svm_pkg::cmd_t    cmd_o
);

  import svm_pkg::*;

  logic voice_ok;
  logic addr_ok;
  logic len_big;
  logic keep;
  logic accept;

  // Take an item whenever the queue has room
  assign in_ch.ready = !fifo_full_i;
  assign accept      = in_ch.valid && in_ch.ready;

  // Range checks
  assign voice_ok = 32'(in_ch.voice) < 32'(NUM_VOICES);
  assign addr_ok  = 32'(in_ch.address) < 32'(MAX_SAMPLES);
  assign len_big  = 32'(in_ch.length) > 32'(MAX_SAMPLES);

  // Classify: ticks always pass, others need a valid voice, writes a valid address
  always_comb begin
    case (kind_e'(in_ch.kind))
      KIND_TICK:    keep = 1'b1;
      KIND_TRIGGER: keep = voice_ok;
      KIND_WRITE:   keep = voice_ok && addr_ok;
      KIND_LENGTH:  keep = voice_ok;
      default:      keep = 1'b0;
    endcase
  end

  assign push_o = accept && keep;

  // Build the command, saturating the length to the region size
  always_comb begin
    cmd_o.op      = kind_e'(in_ch.kind);
    cmd_o.voice   = in_ch.voice;
    cmd_o.address = in_ch.address;
    cmd_o.sample  = in_ch.sample_value;
    cmd_o.length  = len_big ? CMD_LEN_W'(MAX_SAMPLES) : CMD_LEN_W'(in_ch.length);
  end

endmodule

`default_nettype wire

@@ src/svm_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// Sample voice mixer command queue
// Short queue that decouples the front end from the voice engine.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_cmd_fifo (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  svm_pkg::cmd_t    cmd_i,
  input  wire              pop_i,
  output svm_pkg::cmd_t    cmd_o,
  output logic             full_o,
  output logic             empty_o
);

  import svm_pkg::*;

  cmd_t                 mem_q [CMD_FIFO_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_PTR_W:0]   count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = count_q == (CMD_PTR_W+1)'(CMD_FIFO_DEPTH);
  assign empty_o = count_q == '0;
  assign cmd_o   = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ src/svm_back.sv @@
// ----------------------------------------------------------------------------
// Sample voice mixer voice engine
// Executes commands: walks the voices on a tick, mixes, saturates, outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_back #(
  parameter int NUM_VOICES  = 24,
  parameter int MAX_SAMPLES = 131072
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  svm_pkg::cmd_t    cmd_i,
  input  wire              empty_i,
  output logic             pop_o,
  input  wire [14:0]       gain_i,
  svm_out_if.source        out_ch
);

  import svm_pkg::*;

  localparam int VIDX_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int LEN_W    = $clog2(MAX_SAMPLES + 1);
  localparam int DEPTH    = NUM_VOICES * MAX_SAMPLES;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int SUM_W    = SAMPLE_W + $clog2(NUM_VOICES);
  localparam int P_RAW_W  = SUM_W + GAIN_W;
  localparam int PROD_W   = (P_RAW_W > 33) ? P_RAW_W : 33;
  localparam int IDX_LO   = 22;

  bk_state_e state_q, state_d;

  // Voice state
  logic              active_q [NUM_VOICES];
  logic [LEN_W-1:0]  pos_q    [NUM_VOICES];
  logic [LEN_W-1:0]  len_q    [NUM_VOICES];

  // Tick datapath
  logic [VIDX_W-1:0]        vidx_q;
  logic                     hit_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic                     neg_q;
  logic [PROD_W-1:0]        prod_q;
  logic [TANH_W-1:0]        rom_q;
  logic                     sat_q;
  logic                     out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0]      out_data_q;

  // Control strobes
  logic start_tick;
  logic cmd_trig;
  logic cmd_write;
  logic cmd_len;
  logic walk;
  logic acc_en;
  logic load_out;
  logic out_free;
  logic vidx_last;
  logic contrib;

  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SUM_W-1:0]    mag;
  logic [P_RAW_W-1:0]  prod_raw;
  logic [TANH_W-1:0]   level;
  logic [SAMPLE_W-1:0] level_ext;

  assign out_free  = !out_valid_q || out_ch.ready;
  assign vidx_last = vidx_q == VIDX_W'(NUM_VOICES - 1);
  assign contrib   = active_q[vidx_q] && (pos_q[vidx_q] < len_q[vidx_q]);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i && cmd_i.op == KIND_TICK) begin
          state_d = BK_WALK;
        end
      end
      BK_WALK: begin
        if (vidx_last) begin
          state_d = BK_SUM;
        end
      end
      BK_SUM:  state_d = BK_MUL;
      BK_MUL:  state_d = BK_LOOK;
      BK_LOOK: state_d = BK_SEND;
      BK_SEND: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop_o      = 1'b0;
    start_tick = 1'b0;
    cmd_trig   = 1'b0;
    cmd_write  = 1'b0;
    cmd_len    = 1'b0;
    walk       = 1'b0;
    acc_en     = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      BK_IDLE: begin
        pop_o = !empty_i;
        case (cmd_i.op)
          KIND_TICK:    start_tick = !empty_i;
          KIND_TRIGGER: cmd_trig   = !empty_i;
          KIND_WRITE:   cmd_write  = !empty_i;
          KIND_LENGTH:  cmd_len    = !empty_i;
          default:      pop_o      = !empty_i;
        endcase
      end
      BK_WALK: begin
        walk   = 1'b1;
        acc_en = hit_q;
      end
      BK_SUM:  acc_en   = hit_q;
      BK_MUL:  acc_en   = 1'b0;
      BK_LOOK: acc_en   = 1'b0;
      BK_SEND: load_out = out_free;
      default: pop_o    = 1'b0;
    endcase
  end

  // Sample store
  assign wr_addr = ADDR_W'(cmd_i.voice) * ADDR_W'(MAX_SAMPLES) + ADDR_W'(cmd_i.address);
  assign rd_addr = ADDR_W'(vidx_q) * ADDR_W'(MAX_SAMPLES) + ADDR_W'(pos_q[vidx_q]);

  svm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_sample_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_write),
    .wr_addr_i (wr_addr),
    .wr_data_i (cmd_i.sample),
    .rd_en_i   (walk && contrib),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      vidx_q      <= '0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (start_tick) begin
        vidx_q <= '0;
        hit_q  <= 1'b0;
      end else if (walk) begin
        vidx_q <= vidx_q + 1'b1;
        hit_q  <= contrib;
      end else begin
        hit_q  <= 1'b0;
      end
    end
  end

  assign out_valid_d = load_out ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_q);

  // Voice playheads and lengths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        active_q[v] <= 1'b0;
        pos_q[v]    <= '0;
        len_q[v]    <= '0;
      end
    end else begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        if (cmd_trig && (32'(cmd_i.voice) == 32'(v))) begin
          active_q[v] <= 1'b1;
          pos_q[v]    <= '0;
        end else if (walk && contrib && (vidx_q == VIDX_W'(v))) begin
          pos_q[v]    <= pos_q[v] + 1'b1;
        end
        if (cmd_len && (32'(cmd_i.voice) == 32'(v))) begin
          len_q[v] <= LEN_W'(cmd_i.length);
        end
      end
    end
  end

  // Mix, scale and look up
  assign mag      = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign prod_raw = P_RAW_W'(mag) * P_RAW_W'(gain_i);

  always_ff @(posedge clk_i) begin
    if (start_tick) begin
      sum_q <= '0;
    end else if (acc_en) begin
      sum_q <= sum_q + SUM_W'($signed(rd_data));
    end
    if (state_q == BK_MUL) begin
      neg_q  <= sum_q[SUM_W-1];
      prod_q <= PROD_W'(prod_raw);
    end
    if (state_q == BK_LOOK) begin
      rom_q <= TANH_ROM[prod_q[IDX_LO+TANH_IDX_W-1:IDX_LO]];
      sat_q <= |prod_q[PROD_W-1:IDX_LO+TANH_IDX_W];
    end
    if (load_out) begin
      out_data_q <= neg_q ? SAMPLE_W'(-level_ext) : level_ext;
    end
  end

  // Saturate and restore the sign
  assign level     = sat_q ? OUT_MAX : rom_q;
  assign level_ext = {1'b0, level};

  assign out_ch.valid     = out_valid_q;
  assign out_ch.audio_out = out_data_q;

endmodule

`default_nettype wire

@@ src/sample_voice_mixer.sv @@
// Sample voice mixer: a command item goes through a four-entry queue to the
// voice engine, which executes one command at a time. Trigger, sample-write
// and length items are executed as they are popped. A tick walks every voice
// with at most one read of the sample RAM per voice (only playing voices are
// read) and then passes the SUM, MUL, LOOK and SEND states for the final add,
// the gain multiply, the tanh lookup and the output register; that voice
// walk over the single RAM read port sets the rate. Input items
// are accepted one per cycle while the queue has room, and the engine goes
// on with the next command while a finished result waits in the output
// register. The gain register is written whenever its channel is valid.
// ----------------------------------------------------------------------------
// Sample voice mixer top level
// One-shot sample playback for several voices with tanh output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_voice_mixer #(
  parameter int NUM_VOICES  = svm_pkg::NumVoicesDef,
  parameter int MAX_SAMPLES = svm_pkg::MaxSamplesDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  svm_in_if.sink     in_ch,
  svm_out_if.source  out_ch,
  svm_cfg_if.sink    cfg_ch
);

  import svm_pkg::*;

  cmd_t              push_cmd;
  cmd_t              head_cmd;
  logic              push;
  logic              pop;
  logic              fifo_full;
  logic              fifo_empty;
  logic [GAIN_W-1:0] gain_q;

  // Gain register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_ch.valid) begin
      gain_q <= cfg_ch.output_gain;
    end
  end

  svm_front #(
    .NUM_VOICES  (NUM_VOICES),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .in_ch       (in_ch),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  svm_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  svm_back #(
    .NUM_VOICES  (NUM_VOICES),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (head_cmd),
    .empty_i (fifo_empty),
    .pop_o   (pop),
    .gain_i  (gain_q),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

@@ src/svm_checker.sv @@
// ----------------------------------------------------------------------------
// Sample voice mixer port checker
// Watches the top-level channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sample_voice_mixer_defines.svh"

module svm_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [15:0] out_audio
);

  // A stalled result holds
  `SVM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_audio), "result changed while stalled")

  // Saturation is symmetric, the most negative code never appears
  `SVM_ASSERT_IMP(a_out_sym, clk_i, rst_ni, out_valid, out_audio != 16'h8000, "audio_out reached -32768")

  // The empty queue takes items right after reset
  `SVM_ASSERT_IMP(a_rst_ready, clk_i, rst_ni, $past(!rst_ni), in_ready, "input not ready after reset")

  // No result is pending right after reset
  `SVM_ASSERT_IMP(a_rst_idle, clk_i, rst_ni, $past(!rst_ni), !out_valid, "result valid after reset")

endmodule

bind sample_voice_mixer svm_checker u_svm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_audio (out_ch.audio_out)
);

`default_nettype wire

@@ bench/sample_voice_mixer_tb.sv @@
// ----------------------------------------------------------------------------
// Sample voice mixer testbench
// Drives trigger, sample-write, length and tick items into the mixer and
// checks every audio result against a cycle-free model of the voice walk,
// the gain multiply and the tanh table, under random stalls on both sides
// and across several gain settings.
// ----------------------------------------------------------------------------

module sample_voice_mixer_tb;
  import svm_pkg::*;

  localparam int NV            = NumVoicesDef;
  localparam int REGION        = MaxSamplesDef;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 4000;
  localparam int SEG_ITEMS     = 190;
  localparam int SEG_COUNT     = 6;

  localparam logic [GAIN_W-1:0] GAIN_AT_RESET = 15'd26214;
  localparam logic [15:0]       LEVEL_CAP     = 16'd32767;

  typedef longint unsigned u64_t;

  typedef struct {
    kind_e                      kind;
    logic [VOICE_W-1:0]         voice;
    logic [ADDRESS_W-1:0]       addr;
    logic signed [SAMPLE_W-1:0] smp;
    logic [LENGTH_W-1:0]        len;
  } mix_cmd_t;

  typedef struct {
    mix_cmd_t           cmd;
    bit                 typed;
    logic signed [15:0] level;
  } step_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Free-running clock, period 4
  always #2 clk = ~clk;

  svm_in_if  in_ch();
  svm_out_if out_ch();
  svm_cfg_if cfg_ch();

  sample_voice_mixer u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mixer state as the bench sees it
  logic [GAIN_W-1:0]          gain_shadow;
  bit                         voice_on [NV];
  logic [LENGTH_W-1:0]        play_pos [NV];
  logic [LENGTH_W-1:0]        play_len [NV];
  logic signed [SAMPLE_W-1:0] sample_mem [int];
  logic [TANH_W-1:0]          tanh_lut [TANH_ENTRIES];

  logic signed [15:0] level_q [$];
  logic signed [15:0] want_level;
  step_row_t          steps [$];

  int err_count    = 0;
  int in_count     = 0;
  int useful_count = 0;
  int level_count  = 0;
  int gain_writes  = 0;
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int stall_cycles = 0;

  // Fill 32767*tanh(i/256) from the Q24 exponential recurrence
  function automatic void build_lut();
    u64_t e;
    u64_t num;
    u64_t den;
    e = u64_t'(1) << 24;
    for (int i = 0; i < TANH_ENTRIES; i++) begin
      num         = e - (u64_t'(1) << 24);
      den         = e + (u64_t'(1) << 24);
      tanh_lut[i] = TANH_W'((num * 32767 + den / 2) / den);
      e           = (e * 64'd16908801 + (u64_t'(1) << 23)) >> 24;
    end
  endfunction

  // Apply one item to the mixer state; return 1 with the level for a tick
  function automatic bit mix_step(input mix_cmd_t c, output logic signed [15:0] level);
    longint      sum;
    u64_t        mag;
    u64_t        idx;
    logic [15:0] lvl;
    level = '0;
    if (c.kind == KIND_TICK) begin
      sum = 0;
      for (int v = 0; v < NV; v++) begin
        if (voice_on[v] && play_pos[v] < play_len[v]) begin
          sum += longint'(sample_mem[v * REGION + int'(play_pos[v])]);
          play_pos[v]++;
        end
      end
      mag   = u64_t'(sum < 0 ? -sum : sum) * gain_shadow;
      idx   = mag >> 22;
      lvl   = (idx >= TANH_ENTRIES) ? LEVEL_CAP : 16'(tanh_lut[idx[9:0]]);
      level = (sum < 0) ? -lvl : lvl;
      return 1'b1;
    end
    if (c.voice >= NV) return 1'b0;
    case (c.kind)
      KIND_TRIGGER: begin
        voice_on[c.voice] = 1'b1;
        play_pos[c.voice] = '0;
      end
      KIND_WRITE: begin
        sample_mem[c.voice * REGION + int'(c.addr)] = c.smp;
      end
      default: begin
        play_len[c.voice] = (c.len > REGION) ? LENGTH_W'(REGION) : c.len;
      end
    endcase
    return 1'b0;
  endfunction

  // Random fields, biased toward small addresses, short lengths and full-scale samples
  function automatic mix_cmd_t rand_cmd(input kind_e k);
    mix_cmd_t c;
    c.kind  = k;
    c.voice = ($urandom_range(9) == 0) ? VOICE_W'($urandom_range(31, NV))
                                       : VOICE_W'($urandom_range(NV - 1));
    c.addr  = ($urandom_range(7) == 0) ? ADDRESS_W'($urandom)
                                       : ADDRESS_W'($urandom_range(63));
    case ($urandom_range(3))
      0:       c.smp = 16'sh7FFF;
      1:       c.smp = 16'sh8000;
      default: c.smp = SAMPLE_W'($urandom);
    endcase
    case ($urandom_range(7))
      4, 5:    c.len = LENGTH_W'($urandom);
      6:       c.len = LENGTH_W'(REGION);
      7:       c.len = '1;
      default: c.len = LENGTH_W'($urandom_range(40));
    endcase
    return c;
  endfunction

  // Present one item, hold it until accepted, then update the expected levels
  task automatic send_item(input mix_cmd_t c, input bit typed,
                           input logic signed [15:0] typed_level);
    logic signed [15:0] level;
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= c.kind;
    in_ch.voice        <= c.voice;
    in_ch.address      <= c.addr;
    in_ch.sample_value <= c.smp;
    in_ch.length       <= c.len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    in_count++;
    if (c.kind == KIND_TICK || c.voice < NV) useful_count++;
    if (mix_step(c, level)) level_q.push_back(typed ? typed_level : level);
  endtask

  // Drop valid and hold until every pending level has come back
  task automatic wait_drained(input int settle);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (level_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.output_gain <= g;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    gain_shadow = g;
    gain_writes++;
    cfg_ch.valid <= 1'b0;
  endtask

  // Load any sample word a playing voice is about to read, then tick
  task automatic send_tick();
    mix_cmd_t c;
    for (int v = 0; v < NV; v++) begin
      if (voice_on[v] && play_pos[v] < play_len[v] &&
          !sample_mem.exists(v * REGION + int'(play_pos[v]))) begin
        c       = rand_cmd(KIND_WRITE);
        c.voice = VOICE_W'(v);
        c.addr  = ADDRESS_W'(play_pos[v]);
        send_item(c, 1'b0, '0);
      end
    end
    send_item(rand_cmd(KIND_TICK), 1'b0, '0);
  endtask

  // Mostly load-length-trigger sequences and ticks, the rest single noise items
  task automatic run_segment(input int target);
    int       start;
    int       v;
    int       n;
    mix_cmd_t c;
    start = useful_count;
    while (useful_count - start < target) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          v = $urandom_range(NV - 1);
          n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12, 1);
          for (int a = 0; a < n; a++) begin
            c       = rand_cmd(KIND_WRITE);
            c.voice = VOICE_W'(v);
            c.addr  = ADDRESS_W'(a);
            send_item(c, 1'b0, '0);
          end
          c       = rand_cmd(KIND_LENGTH);
          c.voice = VOICE_W'(v);
          c.len   = LENGTH_W'(n);
          send_item(c, 1'b0, '0);
          if ($urandom_range(9) < 7) begin
            c       = rand_cmd(KIND_TRIGGER);
            c.voice = VOICE_W'(v);
            send_item(c, 1'b0, '0);
          end
        end
        3, 4, 5, 6, 7: begin
          if ($urandom_range(99) == 0) wait_drained(0);
          send_tick();
        end
        default: begin
          send_item(rand_cmd(kind_e'($urandom_range(3, 1))), 1'b0, '0);
        end
      endcase
    end
  endtask

  // Receiver: stall at random
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Compare each audio item with the oldest pending level
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (level_q.size() == 0) begin
        err_count++;
        $display("%0t: audio_out %0d with no level pending", $time, out_ch.audio_out);
      end else begin
        want_level = level_q.pop_front();
        level_count++;
        if (out_ch.audio_out !== want_level) begin
          err_count++;
          $display("%0t: audio_out expected %0d, got %0d", $time, want_level,
                   out_ch.audio_out);
        end
      end
    end
  end

  // Watchdog: count cycles without any accepted item
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
      $display("sample_voice_mixer_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [GAIN_W-1:0] g;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_TICK;
    in_ch.voice        = '0;
    in_ch.address      = '0;
    in_ch.sample_value = '0;
    in_ch.length       = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.output_gain = '0;
    out_ch.ready       = 1'b0;

    gain_shadow = GAIN_AT_RESET;
    for (int v = 0; v < NV; v++) begin
      voice_on[v] = 1'b0;
      play_pos[v] = '0;
      play_len[v] = '0;
    end
    build_lut();

    // Directed items; typed levels where they follow directly from the inputs
    steps = '{
      // idle mixer gives silence; tick ignores its other fields
      '{'{KIND_TICK,    5'd31, 17'h1FFFF, 16'sh7FFF, 18'h3FFFF}, 1'b1, 16'sd0},
      // voices past the last one are ignored
      '{'{KIND_TRIGGER, 5'd31, 17'd0,     16'sd0,    18'd0},     1'b0, 16'sd0},
      '{'{KIND_LENGTH,  5'd24, 17'd0,     16'sd0,    18'd3},     1'b0, 16'sd0},
      '{'{KIND_WRITE,   5'd24, 17'd0,     16'sh8000, 18'd0},     1'b0, 16'sd0},
      // oversized and exact-maximum lengths on voices that never play here
      '{'{KIND_LENGTH,  5'd5,  17'd0,     16'sd0,    18'h3FFFF}, 1'b0, 16'sd0},
      '{'{KIND_LENGTH,  5'd6,  17'd0,     16'sd0,    18'd131072}, 1'b0, 16'sd0},
      // full-scale words on the first and last voice
      '{'{KIND_WRITE,   5'd0,  17'd0,     16'sh7FFF, 18'd0},     1'b0, 16'sd0},
      '{'{KIND_WRITE,   5'd0,  17'd1,     16'sh8000, 18'd0},     1'b0, 16'sd0},
      '{'{KIND_WRITE,   5'd23, 17'd0,     16'sh8000, 18'd0},     1'b0, 16'sd0},
      '{'{KIND_WRITE,   5'd23, 17'h1FFFF, 16'sd1,    18'd0},     1'b0, 16'sd0},
      '{'{KIND_LENGTH,  5'd0,  17'd0,     16'sd0,    18'd2},     1'b0, 16'sd0},
      '{'{KIND_LENGTH,  5'd23, 17'd0,     16'sd0,    18'd1},     1'b0, 16'sd0},
      '{'{KIND_TRIGGER, 5'd0,  17'd0,     16'sd0,    18'd0},     1'b0, 16'sd0},
      '{'{KIND_TRIGGER, 5'd23, 17'd0,     16'sd0,    18'd0},     1'b0, 16'sd0},
      // +max and -max nearly cancel: sum -1 rounds to silence
      '{'{KIND_TICK,    5'd0,  17'd0,     16'sd0,    18'd0},     1'b1, 16'sd0},
      '{'{KIND_TICK,    5'd0,  17'd0,     16'sd0,    18'd0},     1'b0, 16'sd0},
      // both voices finished
      '{'{KIND_TICK,    5'd0,  17'd0,     16'sd0,    18'd0},     1'b1, 16'sd0},
      // shorter length keeps the playhead past the end
      '{'{KIND_LENGTH,  5'd0,  17'd0,     16'sd0,    18'd1},     1'b0, 16'sd0},
      '{'{KIND_TICK,    5'd0,  17'd0,     16'sd0,    18'd0},     1'b1, 16'sd0},
      // retrigger restarts at position zero
      '{'{KIND_TRIGGER, 5'd0,  17'd0,     16'sd0,    18'd0},     1'b0, 16'sd0},
      '{'{KIND_TICK,    5'd0,  17'd0,     16'sd0,    18'd0},     1'b0, 16'sd0},
      // zero length plays nothing
      '{'{KIND_LENGTH,  5'd0,  17'd0,     16'sd0,    18'd0},     1'b0, 16'sd0},
      '{'{KIND_TRIGGER, 5'd0,  17'd0,     16'sd0,    18'd0},     1'b0, 16'sd0},
      '{'{KIND_TICK,    5'd0,  17'd0,     16'sd0,    18'd0},     1'b1, 16'sd0}
    };

    in_idle_pct  = 20;
    out_idle_pct = 70;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[i]) send_item(steps[i].cmd, steps[i].typed, steps[i].level);

    // Random segments, each with its own gain, in pairs that share a stall pattern
    for (int s = 0; s < SEG_COUNT; s++) begin
      case (s)
        0:       g = 15'd32767;
        1:       g = 15'd0;
        2:       g = 15'd1;
        4:       g = 15'd16384;
        default: g = GAIN_W'($urandom_range(32767));
      endcase
      wait_drained(SETTLE_CYCLES);
      write_gain(g);
      if (s < 2) begin
        in_idle_pct  = 20;
        out_idle_pct = 70;
      end else if (s < 4) begin
        in_idle_pct  = 70;
        out_idle_pct = 20;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      run_segment(SEG_ITEMS);
    end

    wait_drained(SETTLE_CYCLES);
    if (level_q.size() != 0) err_count++;

    $display("%0d items sent (%0d acted on), %0d audio levels checked, %0d gain writes",
             in_count, useful_count, level_count, gain_writes);
    $display("covered retrigger, length change, saturation, ignored voices and stalls");
    if (err_count == 0) begin
      $display("sample_voice_mixer_tb passed");
    end else begin
      $display("sample_voice_mixer_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/svm_pkg.sv
src/svm_ifs.sv
src/svm_ram.sv
src/svm_front.sv
src/svm_cmd_fifo.sv
src/svm_back.sv
src/sample_voice_mixer.sv
src/svm_checker.sv
bench/sample_voice_mixer_tb.sv
